// ===== rtl/speck_pkg.sv =====
// Shared types, constants and round functions for the Speck64/128 cipher.
package speck_pkg;

    localparam int WORD_W    = 32;
    localparam int KEY_WORDS = 4;
    localparam int ROUNDS    = 27;
    localparam int RND_W     = $clog2(ROUNDS);
    localparam int ADDR_W    = $clog2(KEY_WORDS);
    localparam int ROT_A     = 8;
    localparam int ROT_B     = 3;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [KEY_WORDS-1:0] key_t;
    typedef word_t [KEY_WORDS-2:0] sched_t;
    typedef word_t [ROUNDS-1:0] rk_t;

    typedef struct packed {
        logic  mode;
        word_t x;
        word_t y;
    } item_t;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    function automatic word_t rotr_a(input word_t v);
        return {v[ROT_A-1:0], v[WORD_W-1:ROT_A]};
    endfunction

    function automatic word_t rotl_a(input word_t v);
        return {v[WORD_W-ROT_A-1:0], v[WORD_W-1:WORD_W-ROT_A]};
    endfunction

    function automatic word_t rotr_b(input word_t v);
        return {v[ROT_B-1:0], v[WORD_W-1:ROT_B]};
    endfunction

    function automatic word_t rotl_b(input word_t v);
        return {v[WORD_W-ROT_B-1:0], v[WORD_W-1:WORD_W-ROT_B]};
    endfunction

    function automatic item_t enc_round(input item_t d, input word_t k);
        item_t r;
        r.mode = d.mode;
        r.x    = (rotr_a(d.x) + d.y) ^ k;
        r.y    = rotl_b(d.y) ^ r.x;
        return r;
    endfunction

    function automatic item_t dec_round(input item_t d, input word_t k);
        item_t r;
        r.mode = d.mode;
        r.y    = rotr_b(d.x ^ d.y);
        r.x    = rotl_a((d.x ^ k) - r.y);
        return r;
    endfunction

endpackage

// ===== rtl/speck_keysched.sv =====
// Key registers, iterative key schedule and round key store.
module speck_keysched import speck_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  word_t             cfg_wr_data,
    output logic              busy,
    output rk_t               round_keys
);

    key_t             key_reg, key_next;
    word_t            k_reg, k_next;
    sched_t           l_reg, l_next;
    logic [RND_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    rk_t              rk_reg;
    word_t            t;

    always_comb begin
        key_next = key_reg;
        if (cfg_wr_en) begin
            key_next[cfg_addr] = cfg_wr_data;
        end
        t         = (rotr_a(l_reg[0]) + k_reg) ^ {{(WORD_W-RND_W){1'b0}}, cnt_reg};
        k_next    = k_reg;
        l_next    = l_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (cfg_wr_en) begin
            k_next    = key_next[0];
            for (int i = 0; i < KEY_WORDS-1; i++) begin
                l_next[i] = key_next[i+1];
            end
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (cnt_reg == RND_W'(ROUNDS-1)) begin
                busy_next = 1'b0;
            end else begin
                k_next = rotl_b(k_reg) ^ t;
                for (int i = 0; i < KEY_WORDS-2; i++) begin
                    l_next[i] = l_reg[i+1];
                end
                l_next[KEY_WORDS-2] = t;
                cnt_next = cnt_reg + RND_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            key_reg  <= key_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
        k_reg <= k_next;
        l_reg <= l_next;
        if (busy_reg && !cfg_wr_en) begin
            rk_reg[cnt_reg] <= k_reg;
        end
    end

    assign busy       = busy_reg;
    assign round_keys = rk_reg;

endmodule

// ===== rtl/speck_round.sv =====
// One registered cipher round stage, encrypt or decrypt per item.
module speck_round import speck_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  advance,
    input  logic  in_valid,
    input  item_t in_item,
    input  word_t enc_key,
    input  word_t dec_key,
    output logic  out_valid,
    output item_t out_item
);

    logic  valid_reg;
    item_t item_reg, item_next;

    always_comb begin
        if (in_item.mode == MODE_DEC) begin
            item_next = dec_round(in_item, dec_key);
        end else begin
            item_next = enc_round(in_item, enc_key);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
        if (advance) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/speck64_128_block_cipher.sv =====
// Speck64/128 cipher top level: key schedule and unrolled round pipeline.
// Each accepted block passes through the unrolled round stages, one round per stage, before its result is valid.
// Throughput: one block per cycle; the whole pipeline stalls while a result waits on m_ready.
// A key write reruns the schedule, during which s_ready is low.
// Reset clears the key words to zero and empties the pipeline; round keys are
// undefined until the schedule has run after the first key write.
module speck64_128_block_cipher import speck_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  word_t             cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_mode,
    input  word_t             s_block_low,
    input  word_t             s_block_high,
    output logic              m_valid,
    input  logic              m_ready,
    output word_t             m_result_low,
    output word_t             m_result_high
);

    logic  key_busy;
    rk_t   round_keys;
    logic  advance;
    logic  stage_valid [ROUNDS+1];
    item_t stage_item  [ROUNDS+1];

    speck_keysched u_keysched (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .busy        (key_busy),
        .round_keys  (round_keys)
    );

    assign advance        = !stage_valid[ROUNDS] || m_ready;
    assign s_ready        = advance && !key_busy;
    assign stage_valid[0] = s_valid && s_ready;
    assign stage_item[0]  = '{mode: s_mode, x: s_block_high, y: s_block_low};

    for (genvar i = 0; i < ROUNDS; i++) begin : g_round
        speck_round u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (stage_valid[i]),
            .in_item   (stage_item[i]),
            .enc_key   (round_keys[i]),
            .dec_key   (round_keys[ROUNDS-1-i]),
            .out_valid (stage_valid[i+1]),
            .out_item  (stage_item[i+1])
        );
    end

    assign m_valid       = stage_valid[ROUNDS];
    assign m_result_low  = stage_item[ROUNDS].y;
    assign m_result_high = stage_item[ROUNDS].x;

    a_no_accept_while_sched: assert property (@(posedge aclk) disable iff (!aresetn)
        key_busy |-> !s_ready)
        else $error("input accepted while key schedule runs");

    a_cfg_starts_sched: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> key_busy && !s_ready)
        else $error("key write did not start the schedule");

    a_stall_holds_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_low) && $stable(m_result_high))
        else $error("stalled result changed");

endmodule
